### hdl/dmrs_pkg.sv
// ----------------------------------------------------------------------------
// dmrs_pkg
// Shared types and constants for the downmix / resample / segmenter block.
// ----------------------------------------------------------------------------
package dmrs_pkg;

    localparam int SAMPLE_W      = 24;
    localparam int NUM_CHANNELS  = 8;
    localparam int MAX_CH_DEF    = 8;
    localparam int OUT_W         = 16;
    localparam int CNT_W         = 4;
    localparam int STEP_W        = 28;
    localparam int SEG_W         = 19;
    localparam int PH_W          = STEP_W + 2;
    localparam int FRAC_W        = 24;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_ADDR_W    = 4;

    localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(8388608);
    localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(201326592);
    localparam logic [CNT_W-1:0]  CH_RESET   = CNT_W'(2);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(50331648);
    localparam logic [SEG_W-1:0]  SEG_RESET  = SEG_W'(80000);
    localparam logic [PH_W-1:0]   PH_ONE     = PH_W'(1) << FRAC_W;

    // output scale 32767 = 2^15 - 1, done as shift and subtract
    localparam int SCALE_SHIFT = 15;
    localparam int RND_BIT     = 46;
    localparam int OUT_SHIFT   = 47;

    typedef enum logic [1:0] {
        REG_CHANNELS = 2'd0,
        REG_STEP     = 2'd1,
        REG_SEGLEN   = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV_START,
        ST_DIV,
        ST_CHECK,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic add_en;
    } interp_ctl_t;

endpackage

### hdl/dmrs_lane.sv
// ----------------------------------------------------------------------------
// dmrs_lane
// One channel lane: registers its sample, or zero when the channel is unused.
// ----------------------------------------------------------------------------
module dmrs_lane #(
    parameter int IDX = 0
) (
    input  logic                                  aclk,
    input  logic                                  load,
    input  logic [dmrs_pkg::CNT_W-1:0]            n_ch,
    input  logic signed [dmrs_pkg::SAMPLE_W-1:0]  sample,
    output logic signed [dmrs_pkg::SAMPLE_W-1:0]  lane_out
);
    import dmrs_pkg::*;

    logic signed [SAMPLE_W-1:0] lane_reg;
    logic signed [SAMPLE_W-1:0] lane_next;

    always_comb begin
        lane_next = lane_reg;
        if (load) begin
            lane_next = (n_ch > CNT_W'(IDX)) ? sample : '0;
        end
    end

    always_ff @(posedge aclk) begin
        lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule

### hdl/dmrs_downmix.sv
// ----------------------------------------------------------------------------
// dmrs_downmix
// Channel lanes side by side and the merging adder that sums their samples.
// ----------------------------------------------------------------------------
module dmrs_downmix #(
    parameter int MAX_CHANNELS = dmrs_pkg::MAX_CH_DEF,
    parameter int SUM_W        = dmrs_pkg::SAMPLE_W + $clog2(MAX_CHANNELS)
) (
    input  logic                                  aclk,
    input  logic                                  load,
    input  logic                                  sum_en,
    input  logic [dmrs_pkg::CNT_W-1:0]            n_ch,
    input  logic signed [dmrs_pkg::SAMPLE_W-1:0]  samples [MAX_CHANNELS],
    output logic signed [SUM_W-1:0]               sum_out
);
    import dmrs_pkg::*;

    logic signed [SAMPLE_W-1:0] lane_val [MAX_CHANNELS];
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SUM_W-1:0]    acc;

    for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
        dmrs_lane #(
            .IDX (i)
        ) u_lane (
            .aclk     (aclk),
            .load     (load),
            .n_ch     (n_ch),
            .sample   (samples[i]),
            .lane_out (lane_val[i])
        );
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            acc = acc + SUM_W'(lane_val[i]);
        end
        sum_next = sum_en ? acc : sum_reg;
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    assign sum_out = sum_reg;

endmodule

### hdl/dmrs_divider.sv
// ----------------------------------------------------------------------------
// dmrs_divider
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module dmrs_divider #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  numer,
    input  logic [DEN_W-1:0]  denom,
    output logic              done,
    output logic [NUM_W-1:0]  quot
);
    import dmrs_pkg::*;

    localparam int CW = $clog2(NUM_W);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             qbit;

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, num_reg[NUM_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        if (start) begin
            num_next  = numer;
            rem_next  = '0;
            den_next  = denom;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = qbit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            num_next = {num_reg[NUM_W-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

### hdl/dmrs_interp.sv
// ----------------------------------------------------------------------------
// dmrs_interp
// Linear interpolation, scaling by 32767, rounding and 16-bit saturation.
// ----------------------------------------------------------------------------
module dmrs_interp (
    input  logic                                  aclk,
    input  dmrs_pkg::interp_ctl_t                 ctl,
    input  logic signed [dmrs_pkg::SAMPLE_W-1:0]  prev,
    input  logic signed [dmrs_pkg::SAMPLE_W-1:0]  cur,
    input  logic [dmrs_pkg::FRAC_W-1:0]           frac,
    output logic signed [dmrs_pkg::OUT_W-1:0]     pcm
);
    import dmrs_pkg::*;

    localparam int D_W = SAMPLE_W + 1;
    localparam int V_W = 2 * D_W;
    localparam int W_W = V_W + SCALE_SHIFT + 1;
    localparam int S_W = W_W - OUT_SHIFT;

    logic signed [D_W-1:0] diff;
    logic signed [D_W-1:0] frac_s;
    logic signed [V_W-1:0] prod_reg, prod_next;
    logic signed [V_W-1:0] base;
    logic signed [V_W-1:0] v_reg, v_next;
    logic signed [W_W-1:0] v_ext;
    logic signed [W_W-1:0] w;
    logic signed [S_W-1:0] s;
    logic signed [S_W-1:0] omax;
    logic signed [S_W-1:0] omin;

    always_comb begin
        diff      = D_W'(cur) - D_W'(prev);
        frac_s    = $signed({1'b0, frac});
        prod_next = ctl.mul_en ? diff * frac_s : prod_reg;
        base      = V_W'(prev) <<< FRAC_W;
        v_next    = ctl.add_en ? base + prod_reg : v_reg;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        v_reg    <= v_next;
    end

    always_comb begin
        v_ext = W_W'(v_reg);
        w     = (v_ext <<< SCALE_SHIFT) - v_ext + (W_W'(1) <<< RND_BIT);
        s     = w[W_W-1:OUT_SHIFT];
        omax  = S_W'((1 << (OUT_W - 1)) - 1);
        omin  = -S_W'(1 << (OUT_W - 1));
        if (s > omax) begin
            pcm = omax[OUT_W-1:0];
        end else if (s < omin) begin
            pcm = omin[OUT_W-1:0];
        end else begin
            pcm = s[OUT_W-1:0];
        end
    end

endmodule

### hdl/downmix_resample_segmenter.sv
// a frame is loaded into the lanes, summed and divided into its mono value, one
// quotient bit per cycle over NUM_W bits (NUM_W = 34 at eight channels); each of its
// zero, one or two results then passes the check, multiply, add and output states.
// s_tready is high only in idle; a flush keeps it high, a stalled result holds it low
// reset: synchronous active-low aresetn clears phase, previous sample, segment count,
// the control state and loads the register defaults
// ----------------------------------------------------------------------------
// downmix_resample_segmenter
// Averages channels to mono, resamples to 16 kHz, flags segment ends.
// ----------------------------------------------------------------------------
module downmix_resample_segmenter #(
    parameter int MAX_CHANNELS = dmrs_pkg::MAX_CH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // apb configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dmrs_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [dmrs_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [dmrs_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample_0 .. sample_7, 24 bits each, sample_0 lowest
    input  logic [dmrs_pkg::NUM_CHANNELS*dmrs_pkg::SAMPLE_W-1:0] s_tdata,
    // cmd
    input  logic                                s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pcm_sample
    output logic [dmrs_pkg::OUT_W-1:0]          m_tdata,
    // segment_end
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import dmrs_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(MAX_CHANNELS);
    localparam int DEN_W = CNT_W + 1;
    localparam int NUM_W = SUM_W + 7;
    localparam logic [NUM_W-1:0] BIAS = NUM_W'(1) << (SUM_W + 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  ch_reg, ch_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SEG_W-1:0]  seg_reg, seg_next;

    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic [STEP_W-1:0]          phase_reg, phase_next;
    logic [SEG_W-1:0]           fill_reg, fill_next;
    logic signed [SAMPLE_W-1:0] cur_reg, cur_next;
    logic [PH_W-1:0]            ph_reg, ph_next;
    logic [1:0]                 k_reg, k_next;

    logic                 mvalid_reg, mvalid_next;
    logic [OUT_W-1:0]     mdata_reg, mdata_next;
    logic                 muser_reg, muser_next;
    logic                 mlast_reg, mlast_next;

    logic [CNT_W-1:0]  n_ch;
    logic [STEP_W-1:0] step_c;
    logic [DEN_W-1:0]  den;
    logic [NUM_W-1:0]  numer;
    logic [NUM_W-1:0]  quot;
    logic [NUM_W-1:0]  q_unb;
    logic              div_start;
    logic              div_done;
    logic              lane_load;
    logic              sum_en;
    logic              in_acc;
    logic              out_free;
    logic              seg_hit;
    logic [PH_W-1:0]   ph_adv;
    logic [PH_W-1:0]   ph_wrap;
    logic              cfg_wr;
    interp_ctl_t       ictl;

    logic signed [SAMPLE_W-1:0] samples [MAX_CHANNELS];
    logic signed [SUM_W-1:0]    sum;
    logic signed [OUT_W-1:0]    pcm;

    for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_unpack
        assign samples[i] = s_tdata[i*SAMPLE_W +: SAMPLE_W];
    end

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_idx_t'(paddr[3:2]))
            REG_CHANNELS: prdata = CFG_DATA_W'(ch_reg);
            REG_STEP:     prdata = CFG_DATA_W'(step_reg);
            REG_SEGLEN:   prdata = CFG_DATA_W'(seg_reg);
            default:      prdata = '0;
        endcase
    end

    // clamped settings
    always_comb begin
        if (ch_reg == '0) begin
            n_ch = CNT_W'(1);
        end else if (ch_reg > CNT_W'(MAX_CHANNELS)) begin
            n_ch = CNT_W'(MAX_CHANNELS);
        end else begin
            n_ch = ch_reg;
        end
        if (step_reg < STEP_MIN) begin
            step_c = STEP_MIN;
        end else if (step_reg > STEP_MAX) begin
            step_c = STEP_MAX;
        end else begin
            step_c = step_reg;
        end
        den = {n_ch, 1'b0};
        // 2*sum + n, biased positive by den * 2^(SUM_W+1)
        numer = (NUM_W'(sum) <<< 1) + NUM_W'(n_ch) + (NUM_W'(den) << (SUM_W + 1));
        q_unb = quot - BIAS;
    end

    dmrs_downmix #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SUM_W        (SUM_W)
    ) u_downmix (
        .aclk    (aclk),
        .load    (lane_load),
        .sum_en  (sum_en),
        .n_ch    (n_ch),
        .samples (samples),
        .sum_out (sum)
    );

    dmrs_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (numer),
        .denom   (den),
        .done    (div_done),
        .quot    (quot)
    );

    dmrs_interp u_interp (
        .aclk (aclk),
        .ctl  (ictl),
        .prev (prev_reg),
        .cur  (cur_reg),
        .frac (ph_reg[FRAC_W-1:0]),
        .pcm  (pcm)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;
    assign seg_hit  = ({1'b0, fill_reg} + 1'b1) >= {1'b0, seg_reg};
    assign ph_adv   = ph_reg + PH_W'(step_c);
    assign ph_wrap  = (ph_reg >= PH_ONE) ? ph_reg - PH_ONE : ph_reg;

    always_comb begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        step_next   = step_reg;
        seg_next    = seg_reg;
        prev_next   = prev_reg;
        phase_next  = phase_reg;
        fill_next   = fill_reg;
        cur_next    = cur_reg;
        ph_next     = ph_reg;
        k_next      = k_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        mlast_next  = mlast_reg;
        lane_load   = 1'b0;
        sum_en      = 1'b0;
        div_start   = 1'b0;
        ictl        = '0;

        if (cfg_wr) begin
            case (reg_idx_t'(paddr[3:2]))
                REG_CHANNELS: ch_next   = pwdata[CNT_W-1:0];
                REG_STEP:     step_next = pwdata[STEP_W-1:0];
                REG_SEGLEN:   seg_next  = pwdata[SEG_W-1:0];
                default:      ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser) begin
                        phase_next = '0;
                        prev_next  = '0;
                        fill_next  = '0;
                    end else begin
                        lane_load  = 1'b1;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                sum_en     = 1'b1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    cur_next   = q_unb[SAMPLE_W-1:0];
                    ph_next    = PH_W'(phase_reg);
                    k_next     = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (ph_reg < PH_ONE && k_reg < 2'd2) begin
                    state_next = ST_MUL;
                end else begin
                    phase_next = ph_wrap[STEP_W-1:0];
                    prev_next  = cur_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL: begin
                ictl.mul_en = 1'b1;
                state_next  = ST_ADD;
            end
            ST_ADD: begin
                ictl.add_en = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    mdata_next  = pcm;
                    muser_next  = seg_hit;
                    mlast_next  = (k_reg == 2'd1) || (ph_adv >= PH_ONE);
                    fill_next   = seg_hit ? '0 : fill_reg + 1'b1;
                    ph_next     = ph_adv;
                    k_next      = k_reg + 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ch_reg     <= CH_RESET;
            step_reg   <= STEP_RESET;
            seg_reg    <= SEG_RESET;
            prev_reg   <= '0;
            phase_reg  <= '0;
            fill_reg   <= '0;
            k_reg      <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ch_reg     <= ch_next;
            step_reg   <= step_next;
            seg_reg    <= seg_next;
            prev_reg   <= prev_next;
            phase_reg  <= phase_next;
            fill_reg   <= fill_next;
            k_reg      <= k_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        ph_reg    <= ph_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
        mlast_reg <= mlast_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign m_tlast  = mlast_reg;

endmodule

### hdl/dmrs_checker.sv
// ----------------------------------------------------------------------------
// dmrs_checker
// Port-level checks for the downmix / resample / segmenter block.
// ----------------------------------------------------------------------------
module dmrs_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [dmrs_pkg::OUT_W-1:0]  m_tdata,
    input logic                        m_tuser,
    input logic                        m_tlast
);
    import dmrs_pkg::*;

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // flush request leaves the block ready
    a_flush_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> s_tready)
        else $error("not ready after flush");

    // audio request occupies the block
    a_frame_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> !s_tready)
        else $error("ready right after frame");

endmodule

bind downmix_resample_segmenter dmrs_checker u_dmrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### tb/sv/downmix_resample_segmenter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// downmix_resample_segmenter_tb
// Self-checking bench for the mono downmix, 16 kHz linear resampler and
// segment flagging. A scoreboard class keeps its own copy of the converter
// state and registers, predicts the pcm samples of every accepted frame and
// compares them in order with the result stream. Directed frames cover
// extremes, rounding ties, flushes and clamped register values, followed by
// random frames over many register settings with random stalls on both sides.
// ----------------------------------------------------------------------------
module downmix_resample_segmenter_tb;
    import dmrs_pkg::*;

    localparam int DATA_W         = NUM_CHANNELS * SAMPLE_W;
    localparam int REG_UNUSED     = 3;
    localparam int DRAIN_CYCLES   = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 14;
    localparam int PHASE_FRAMES   = 100;
    localparam longint ONE_Q24    = longint'(1) << FRAC_W;
    localparam longint PCM_MAX    = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint PCM_MIN    = -(longint'(1) << (OUT_W - 1));

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    bit idling = 1'b1;
    bit hold_req;

    class pcm_scoreboard;
        typedef struct {
            logic [OUT_W-1:0] pcm;
            logic             seg_end;
            logic             last;
        } pcm_result_t;

        logic [CNT_W-1:0]  ch_reg;
        logic [STEP_W-1:0] step_reg;
        logic [SEG_W-1:0]  seglen_reg;
        longint            prev_mono;
        longint            phase;
        int unsigned       fill;
        pcm_result_t       pcm_pending[$];
        int                mismatches;

        function new();
            ch_reg     = CH_RESET;
            step_reg   = STEP_RESET;
            seglen_reg = SEG_RESET;
            prev_mono  = 0;
            phase      = 0;
            fill       = 0;
            mismatches = 0;
        endfunction

        function void write_reg(int idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_CHANNELS: ch_reg = value[CNT_W-1:0];
                REG_STEP:     step_reg = value[STEP_W-1:0];
                REG_SEGLEN:   seglen_reg = value[SEG_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [CFG_DATA_W-1:0] reg_value(int idx);
            case (idx)
                REG_CHANNELS: return CFG_DATA_W'(ch_reg);
                REG_STEP:     return CFG_DATA_W'(step_reg);
                default:      return CFG_DATA_W'(seglen_reg);
            endcase
        endfunction

        function int pending_count();
            return pcm_pending.size();
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        function void note_frame(logic flush, logic [DATA_W-1:0] data);
            longint      sum, num, den, cur, ph, v, s;
            int          n, c, cnt;
            longint      step;
            pcm_result_t res[2];
            if (flush) begin
                prev_mono = 0;
                phase     = 0;
                fill      = 0;
                return;
            end
            n = (ch_reg == 0) ? 1 : ((ch_reg > MAX_CH_DEF) ? MAX_CH_DEF : int'(ch_reg));
            step = (step_reg < STEP_MIN) ? longint'(STEP_MIN) :
                   ((step_reg > STEP_MAX) ? longint'(STEP_MAX) : longint'(step_reg));
            sum = 0;
            for (c = 0; c < n; c++)
                sum += longint'(signed'(data[c*SAMPLE_W +: SAMPLE_W]));
            // mono average, nearest with ties up
            num = 2 * sum + n;
            den = 2 * n;
            cur = num / den;
            if ((num % den) != 0 && num < 0)
                cur--;
            ph  = phase;
            cnt = 0;
            while (ph < ONE_Q24 && cnt < 2) begin
                v = prev_mono * ONE_Q24 + (cur - prev_mono) * ph;
                s = (v * 32767 + (longint'(1) << 46)) >>> 47;
                if (s > PCM_MAX)
                    s = PCM_MAX;
                if (s < PCM_MIN)
                    s = PCM_MIN;
                res[cnt].pcm  = s[OUT_W-1:0];
                res[cnt].last = 1'b0;
                if (fill + 1 >= seglen_reg) begin
                    fill = 0;
                    res[cnt].seg_end = 1'b1;
                end else begin
                    fill = (fill + 1) & ((1 << SEG_W) - 1);
                    res[cnt].seg_end = 1'b0;
                end
                cnt++;
                ph += step;
            end
            if (ph >= ONE_Q24)
                ph -= ONE_Q24;
            phase     = ph & ((longint'(1) << STEP_W) - 1);
            prev_mono = cur;
            if (cnt > 0)
                res[cnt-1].last = 1'b1;
            for (c = 0; c < cnt; c++)
                pcm_pending.push_back(res[c]);
        endfunction

        function void check_pcm(logic [OUT_W-1:0] pcm, logic seg_end, logic last);
            pcm_result_t exp_r;
            if (pcm_pending.size() == 0) begin
                note_mismatch($sformatf("unexpected sample pcm=%0d seg_end=%b last=%b",
                                        $signed(pcm), seg_end, last));
                return;
            end
            exp_r = pcm_pending.pop_front();
            if (pcm !== exp_r.pcm || seg_end !== exp_r.seg_end || last !== exp_r.last)
                note_mismatch($sformatf(
                    "pcm exp %0d got %0d, seg_end exp %b got %b, last exp %b got %b",
                    $signed(exp_r.pcm), $signed(pcm), exp_r.seg_end, seg_end,
                    exp_r.last, last));
        endfunction
    endclass

    pcm_scoreboard sb = new();

    downmix_resample_segmenter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_pcm(m_tdata, m_tuser, m_tlast);
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin : ready_driver
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && idling && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 6);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("downmix_resample_segmenter verification failed");
        $finish;
    end

    task automatic apb_write(int idx, logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.write_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic check_registers();
        int idx;
        for (idx = 0; idx < 3; idx++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= CFG_ADDR_W'(idx * 4);
            @(negedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            if (prdata !== sb.reg_value(idx))
                sb.note_mismatch($sformatf("register %0d read exp %h got %h",
                                           idx, sb.reg_value(idx), prdata));
            @(negedge aclk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(negedge aclk);
        end
    endtask

    // upper pwdata bits carry noise, the block keeps only the register width
    task automatic configure(int unsigned ch, int unsigned step, int unsigned seglen);
        apb_write(REG_CHANNELS, (32'($urandom()) << CNT_W) | ch);
        apb_write(REG_STEP, (32'($urandom()) << STEP_W) | step);
        apb_write(REG_SEGLEN, (32'($urandom()) << SEG_W) | seglen);
        if ($urandom_range(0, 3) == 0)
            apb_write(REG_UNUSED, $urandom());
        check_registers();
    endtask

    task automatic send_request(logic flush, logic [DATA_W-1:0] data);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= flush;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        sb.note_frame(flush, data);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending_count() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return SAMPLE_W'($urandom_range(0, 6)) - SAMPLE_W'(3);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    initial begin : stimulus
        int                p, k, c;
        int unsigned       ch, step, seglen;
        logic [DATA_W-1:0] data;
        logic              flush;

        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults: two channels, step 3.0
        check_registers();
        send_request(1'b0, {{6{24'h800000}}, 24'h000000, 24'h000001});
        send_request(1'b0, {{6{24'h7FFFFF}}, 24'h000000, 24'hFFFFFF});
        send_request(1'b0, {{6{24'h800000}}, 24'h7FFFFF, 24'h7FFFFF});
        send_request(1'b0, {{6{24'h7FFFFF}}, 24'h800000, 24'h800000});
        send_request(1'b0, {{6{24'h000000}}, 24'h800000, 24'h7FFFFF});
        send_request(1'b1, {8{24'h7FFFFF}});
        send_request(1'b0, {8{24'h000000}});
        settle();

        // eight channels, step below range, zero segment length
        configure(8, 0, 0);
        send_request(1'b0, {8{24'h7FFFFF}});
        send_request(1'b0, {8{24'h800000}});
        send_request(1'b0, {8{24'h7FFFFF}});
        send_request(1'b0, {{4{24'h7FFFFF}}, {4{24'h800000}}});
        send_request(1'b0, {{7{24'h000000}}, 24'hFFFFFC});
        send_request(1'b0, {{7{24'h000000}}, 24'h000004});
        settle();

        // zero channels, step above range, segment length one
        configure(0, 32'h0FFF_FFFF, 1);
        send_request(1'b0, {8{24'h7FFFFF}});
        send_request(1'b1, {8{24'h000000}});
        send_request(1'b0, {8{24'h800000}});
        send_request(1'b0, {8{24'h000000}});
        settle();

        // channel count above range, fractional step, longest segment
        configure(15, 32'h00C0_0001, (1 << SEG_W) - 1);
        send_request(1'b0, {8{24'h7FFFFF}});
        send_request(1'b0, {8{24'h800000}});
        send_request(1'b0, {8{24'h7FFFFF}});
        send_request(1'b0, {8{24'h800000}});
        settle();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            case ($urandom_range(0, 5))
                0:       step = $urandom() & ((1 << STEP_W) - 1);
                1:       step = STEP_MIN;
                2:       step = STEP_MAX;
                default: step = $urandom_range(STEP_MIN, STEP_MAX);
            endcase
            case ($urandom_range(0, 7))
                0:       seglen = 0;
                1:       seglen = $urandom_range(0, (1 << SEG_W) - 1);
                default: seglen = $urandom_range(1, 40);
            endcase
            // two results per frame while the receiver holds off
            if (p == 2)
                step = STEP_MIN;
            configure(ch, step, seglen);
            idling = (p < RANDOM_PHASES - 2);
            if (p == 2)
                hold_req = 1'b1;
            for (k = 0; k < PHASE_FRAMES; k++) begin
                flush = ($urandom_range(0, 39) == 0);
                for (c = 0; c < NUM_CHANNELS; c++)
                    data[c*SAMPLE_W +: SAMPLE_W] = pick_sample();
                send_request(flush, data);
            end
            settle();
        end

        if (sb.mismatches == 0)
            $display("downmix_resample_segmenter verification clean");
        else
            $display("downmix_resample_segmenter verification failed");
        $finish;
    end
endmodule

### sim.f
hdl/dmrs_pkg.sv
hdl/dmrs_lane.sv
hdl/dmrs_downmix.sv
hdl/dmrs_divider.sv
hdl/dmrs_interp.sv
hdl/downmix_resample_segmenter.sv
hdl/dmrs_checker.sv
tb/sv/downmix_resample_segmenter_tb.sv
